// ===== rtl/adam_weight_update_unit_assert.svh =====
// ----------------------------------------------------------------------------
// adam weight update assertion macros
// shared property forms for the weight update engine checks
// ----------------------------------------------------------------------------
`ifndef ADAM_WEIGHT_UPDATE_UNIT_ASSERT_SVH
`define ADAM_WEIGHT_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define AWU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AWU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/awu_pkg.sv =====
// ----------------------------------------------------------------------------
// awu_pkg
// types, constants and codes shared by the weight update engine
// ----------------------------------------------------------------------------
`default_nettype none

package awu_pkg;

  localparam int NUM_WEIGHTS = 4096;
  localparam int ADDR_W      = $clog2(NUM_WEIGHTS);

  // serial multiplier
  localparam int ACC_W     = 67;
  localparam int MCAND_W   = 34;
  localparam int MULT_W    = 32;
  localparam int MUL_CNT_W = $clog2(MULT_W);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MULT_W - 1);

  // serial divider / square root
  localparam int NUM_W    = 64;
  localparam int DEN_W    = 37;
  localparam int ROOT_W   = 28;
  localparam int DS_CNT_W = $clog2(NUM_W);
  localparam logic [DS_CNT_W-1:0] DIV_LAST  = DS_CNT_W'(NUM_W - 1);
  localparam logic [DS_CNT_W-1:0] SQRT_LAST = DS_CNT_W'(ROOT_W - 1);

  localparam logic [24:0] ONE_Q24 = 25'h100_0000;

  // commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_UPDATE  = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_LEARNING_RATE = 3'd0;
  localparam logic [2:0] REG_BETA_ONE      = 3'd1;
  localparam logic [2:0] REG_BETA_TWO      = 3'd2;
  localparam logic [2:0] REG_EPSILON       = 3'd3;
  localparam logic [2:0] REG_USE_ADAM      = 3'd4;

  // register reset values
  localparam logic [23:0] LEARNING_RATE_RST = 24'd1677722;
  localparam logic [23:0] BETA_ONE_RST      = 24'd15099494;
  localparam logic [23:0] BETA_TWO_RST      = 24'd16760439;
  localparam logic [31:0] EPSILON_RST       = 32'd43;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_DISPATCH,
    ST_GRAD,
    ST_PLAIN,
    ST_BIAS,
    ST_M1,
    ST_M2,
    ST_G2,
    ST_V1,
    ST_V2,
    ST_MHAT,
    ST_VHAT,
    ST_SQRT,
    ST_NUM,
    ST_DELTA,
    ST_WADD,
    ST_ADV1,
    ST_ADV2,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               start;
    logic               clear;
    logic               msb_neg;
    logic [MCAND_W-1:0] mcand;
    logic [MULT_W-1:0]  mult;
  } mul_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ACC_W-1:0] acc;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic             is_sqrt;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } ds_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
  } ds_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/awu_ram.sv =====
// ----------------------------------------------------------------------------
// awu_ram
// single port ram, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module awu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/awu_mul.sv =====
// ----------------------------------------------------------------------------
// awu_mul
// bit-serial shift-add multiply accumulate, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module awu_mul (
  input  logic               clk,
  input  logic               rst,
  input  awu_pkg::mul_req_t  req,
  output awu_pkg::mul_rsp_t  rsp
);

  logic signed [awu_pkg::ACC_W-1:0] acc;
  logic signed [awu_pkg::ACC_W-1:0] mc;
  logic signed [awu_pkg::ACC_W-1:0] term;
  logic [awu_pkg::MULT_W-1:0]       mult;
  logic [awu_pkg::MUL_CNT_W-1:0]    cnt;
  logic                             msb_neg;
  logic                             busy;
  logic                             done;

  // top multiplier bit has negative weight for a signed multiplier
  always_comb begin
    term = '0;
    if (mult[0]) begin
      term = (msb_neg && cnt == awu_pkg::MUL_LAST) ? -mc : mc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == awu_pkg::MUL_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      if (req.clear) begin
        acc <= '0;
      end
      mc <= {{(awu_pkg::ACC_W - awu_pkg::MCAND_W){req.mcand[awu_pkg::MCAND_W-1]}},
             req.mcand};
      mult    <= req.mult;
      msb_neg <= req.msb_neg;
    end else if (busy) begin
      acc  <= acc + term;
      mc   <= mc <<< 1;
      mult <= mult >> 1;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.acc  = acc;

endmodule

`default_nettype wire

// ===== rtl/awu_divsqrt.sv =====
// ----------------------------------------------------------------------------
// awu_divsqrt
// restoring divider (one quotient bit a cycle) and square root
// (two radicand bits a cycle) sharing one subtract and compare
// ----------------------------------------------------------------------------
`default_nettype none

module awu_divsqrt (
  input  logic              clk,
  input  logic              rst,
  input  awu_pkg::ds_req_t  req,
  output awu_pkg::ds_rsp_t  rsp
);

  logic [awu_pkg::NUM_W-1:0]    num_sh;
  logic [awu_pkg::NUM_W-1:0]    quo;
  logic [awu_pkg::DEN_W-1:0]    den;
  logic [awu_pkg::DEN_W:0]      rem;
  logic [awu_pkg::DEN_W:0]      rem_sh;
  logic [awu_pkg::DEN_W:0]      sub_op;
  logic [awu_pkg::DEN_W+1:0]    diff;
  logic [awu_pkg::DS_CNT_W-1:0] cnt;
  logic [awu_pkg::DS_CNT_W-1:0] last;
  logic                         is_sqrt;
  logic                         busy;
  logic                         done;
  logic                         ge;

  always_comb begin
    if (is_sqrt) begin
      rem_sh = {rem[awu_pkg::DEN_W-2:0], num_sh[awu_pkg::NUM_W-1 -: 2]};
      sub_op = {quo[awu_pkg::DEN_W-2:0], 2'b01};
      last   = awu_pkg::SQRT_LAST;
    end else begin
      rem_sh = {rem[awu_pkg::DEN_W-1:0], num_sh[awu_pkg::NUM_W-1]};
      sub_op = {1'b0, den};
      last   = awu_pkg::DIV_LAST;
    end
    diff = {1'b0, rem_sh} - {1'b0, sub_op};
    ge   = ~diff[awu_pkg::DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh  <= req.num;
      den     <= req.den;
      is_sqrt <= req.is_sqrt;
      rem     <= '0;
      quo     <= '0;
    end else if (busy) begin
      num_sh <= is_sqrt ? (num_sh << 2) : (num_sh << 1);
      rem    <= ge ? diff[awu_pkg::DEN_W:0] : rem_sh;
      quo    <= {quo[awu_pkg::NUM_W-2:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

`default_nettype wire

// ===== rtl/adam_weight_update_unit.sv =====
// ----------------------------------------------------------------------------
// adam_weight_update_unit
// weight update engine: load, advance and update items over a weight store
// with first and second moments, bias-corrected adam step in q8.24
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                  payload
// item      in         item_valid / item_stall    cmd, weight_index, weight_value,
//                                                 error_term, activation, is_bias
// result    out        result_valid / result_stall out_index, new_weight,
//                                                 applied_delta, saturated, fault
// cfg       in         cfg_we (no wait)           cfg_index, cfg_data
//
// one item at a time; the serial multiplier and the serial divider / square
// root set the length of an item: a load uses neither unit, a bias step runs
// one product, a plain step and an advance two, and a full adam update seven
// products, two divides, one root and the final divide; the block passes
// back through its idle state before the next item is taken.
// rst is synchronous; config returns to its defaults, beta powers to one.
// a finished result sits in the output register; the next item is taken
// while it waits and only stalls at its own end if the result is not taken.
//
`default_nettype none
`include "adam_weight_update_unit_assert.svh"

module adam_weight_update_unit (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  cmd,
  input  logic [11:0] weight_index,
  input  logic signed [31:0] weight_value,
  input  logic signed [31:0] error_term,
  input  logic signed [31:0] activation,
  input  logic        is_bias,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [11:0] out_index,
  output logic signed [31:0] new_weight,
  output logic signed [31:0] applied_delta,
  output logic        saturated,
  output logic        fault,
  // config port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // clip of a wide signed value to signed 32, flag in the top bit
  function automatic logic [32:0] clip_s32(input logic [awu_pkg::ACC_W-1:0] x);
    logic [32:0] r;
    if ((&x[awu_pkg::ACC_W-1:31]) || !(|x[awu_pkg::ACC_W-1:31])) begin
      r = {1'b0, x[31:0]};
    end else if (x[awu_pkg::ACC_W-1]) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b1, 32'h7fff_ffff};
    end
    return r;
  endfunction

  // magnitude plus sign to signed 32 with clip
  function automatic logic [32:0] sclip(input logic [awu_pkg::NUM_W-1:0] q,
                                        input logic neg);
    logic [32:0] r;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, 32'd0 - q[31:0]};
      end
    end else begin
      if (q > 64'h7fff_ffff) begin
        r = {1'b1, 32'h7fff_ffff};
      end else begin
        r = {1'b0, q[31:0]};
      end
    end
    return r;
  endfunction

  // config registers
  logic [23:0] learning_rate;
  logic [23:0] beta_one;
  logic [23:0] beta_two;
  logic [31:0] epsilon;
  logic        use_adam;

  // running beta powers
  logic [24:0] beta_one_power;
  logic [24:0] beta_two_power;

  awu_pkg::state_t state, state_next;
  logic            launched;

  // item registers
  logic [1:0]        cmd_r;
  logic [11:0]       idx_r;
  logic signed [31:0] wval_r;
  logic signed [31:0] err_r;
  logic signed [31:0] act_r;
  logic              bias_r;

  // working registers
  logic [31:0] g_r;
  logic [31:0] mn_r;
  logic [31:0] g2_r;
  logic [31:0] vn_r;
  logic [31:0] mhat_r;
  logic [31:0] vhat_r;
  logic [awu_pkg::DEN_W-1:0] den_r;
  logic [31:0] delta_r;
  logic [31:0] nw_r;
  logic        sat_r;
  logic        fault_r;
  logic        adam_wr;

  // units
  awu_pkg::mul_req_t mul_req;
  awu_pkg::mul_rsp_t mul_rsp;
  awu_pkg::ds_req_t  ds_req;
  awu_pkg::ds_rsp_t  ds_rsp;
  logic              mul_done;
  logic              ds_done;

  // store ports
  logic [awu_pkg::ADDR_W-1:0] slot;
  logic        w_we, m_we, v_we;
  logic [31:0] w_wd, m_wd, v_wd;
  logic [31:0] w_rd, m_rd, v_rd;

  // derived values
  logic [awu_pkg::ACC_W-1:0] acc;
  logic [awu_pkg::ACC_W-1:0] acc_q24;
  logic [32:0] acc_clip;
  logic [32:0] quo_clip;
  logic [31:0] g_abs;
  logic [31:0] mn_abs;
  logic [31:0] mhat_abs;
  logic [24:0] b1_comp;
  logic [24:0] b2_comp;
  logic [24:0] c1;
  logic [24:0] c2;
  logic        adam_fault;
  logic [32:0] wsum;
  logic [32:0] wsum_clip;
  logic [awu_pkg::DEN_W-1:0] den_calc;
  logic        item_take;
  logic        result_free;

  assign slot        = idx_r[awu_pkg::ADDR_W-1:0];
  assign item_take   = item_valid && !item_stall;
  assign result_free = !result_valid || !result_stall;
  assign mul_done    = mul_rsp.done && launched;
  assign ds_done     = ds_rsp.done && launched;

  assign acc      = mul_rsp.acc;
  assign acc_q24  = $signed(acc) >>> 24;
  assign acc_clip = clip_s32(acc_q24);
  assign quo_clip = sclip(ds_rsp.quo, (state == awu_pkg::ST_DELTA) ? mhat_r[31] : mn_r[31]);

  assign g_abs    = g_r[31] ? (32'd0 - g_r) : g_r;
  assign mn_abs   = mn_r[31] ? (32'd0 - mn_r) : mn_r;
  assign mhat_abs = mhat_r[31] ? (32'd0 - mhat_r) : mhat_r;
  assign b1_comp  = awu_pkg::ONE_Q24 - {1'b0, beta_one};
  assign b2_comp  = awu_pkg::ONE_Q24 - {1'b0, beta_two};
  assign c1       = awu_pkg::ONE_Q24 - beta_one_power;
  assign c2       = awu_pkg::ONE_Q24 - beta_two_power;

  // adam needs at least one advance on both powers
  assign adam_fault = use_adam &&
                      (beta_one_power >= awu_pkg::ONE_Q24 ||
                       beta_two_power >= awu_pkg::ONE_Q24);

  assign wsum      = {w_rd[31], w_rd} + {delta_r[31], delta_r};
  assign wsum_clip = (wsum[32] == wsum[31]) ? {1'b0, wsum[31:0]} :
                     (wsum[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7fff_ffff});

  // sqrt(vhat * 2^24) in q4.32 plus epsilon; an all-zero guard becomes one lsb
  always_comb begin
    den_calc = {1'b0, ds_rsp.quo[awu_pkg::ROOT_W-1:0], 8'h00} + {5'd0, epsilon};
    if (den_calc == '0) begin
      den_calc = awu_pkg::DEN_W'(1);
    end
  end

  // ---------------------------------------------------------------- stores
  awu_ram #(.WIDTH(32), .DEPTH(awu_pkg::NUM_WEIGHTS)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .addr  (slot),
    .wdata (w_wd),
    .rdata (w_rd)
  );

  awu_ram #(.WIDTH(32), .DEPTH(awu_pkg::NUM_WEIGHTS)) u_first_ram (
    .clk   (clk),
    .we    (m_we),
    .addr  (slot),
    .wdata (m_wd),
    .rdata (m_rd)
  );

  awu_ram #(.WIDTH(32), .DEPTH(awu_pkg::NUM_WEIGHTS)) u_second_ram (
    .clk   (clk),
    .we    (v_we),
    .addr  (slot),
    .wdata (v_wd),
    .rdata (v_rd)
  );

  // ---------------------------------------------------------------- units
  awu_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  awu_divsqrt u_divsqrt (
    .clk (clk),
    .rst (rst),
    .req (ds_req),
    .rsp (ds_rsp)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      awu_pkg::ST_IDLE:     if (item_valid) state_next = awu_pkg::ST_READ;
      awu_pkg::ST_READ:     state_next = awu_pkg::ST_DISPATCH;
      awu_pkg::ST_DISPATCH: begin
        unique case (cmd_r)
          awu_pkg::CMD_LOAD:    state_next = awu_pkg::ST_FINISH;
          awu_pkg::CMD_ADVANCE: state_next = awu_pkg::ST_ADV1;
          awu_pkg::CMD_UPDATE: begin
            if (bias_r) begin
              state_next = awu_pkg::ST_BIAS;
            end else if (adam_fault) begin
              state_next = awu_pkg::ST_FINISH;
            end else begin
              state_next = awu_pkg::ST_GRAD;
            end
          end
          default: state_next = awu_pkg::ST_FINISH;
        endcase
      end
      awu_pkg::ST_GRAD:  if (mul_done) state_next = use_adam ? awu_pkg::ST_M1 : awu_pkg::ST_PLAIN;
      awu_pkg::ST_PLAIN: if (mul_done) state_next = awu_pkg::ST_WADD;
      awu_pkg::ST_BIAS:  if (mul_done) state_next = awu_pkg::ST_WADD;
      awu_pkg::ST_M1:    if (mul_done) state_next = awu_pkg::ST_M2;
      awu_pkg::ST_M2:    if (mul_done) state_next = awu_pkg::ST_G2;
      awu_pkg::ST_G2:    if (mul_done) state_next = awu_pkg::ST_V1;
      awu_pkg::ST_V1:    if (mul_done) state_next = awu_pkg::ST_V2;
      awu_pkg::ST_V2:    if (mul_done) state_next = awu_pkg::ST_MHAT;
      awu_pkg::ST_MHAT:  if (ds_done)  state_next = awu_pkg::ST_VHAT;
      awu_pkg::ST_VHAT:  if (ds_done)  state_next = awu_pkg::ST_SQRT;
      awu_pkg::ST_SQRT:  if (ds_done)  state_next = awu_pkg::ST_NUM;
      awu_pkg::ST_NUM:   if (mul_done) state_next = awu_pkg::ST_DELTA;
      awu_pkg::ST_DELTA: if (ds_done)  state_next = awu_pkg::ST_WADD;
      awu_pkg::ST_WADD:  state_next = awu_pkg::ST_FINISH;
      awu_pkg::ST_ADV1:  if (mul_done) state_next = awu_pkg::ST_ADV2;
      awu_pkg::ST_ADV2:  if (mul_done) state_next = awu_pkg::ST_FINISH;
      awu_pkg::ST_FINISH: if (result_free) state_next = awu_pkg::ST_IDLE;
      default: state_next = awu_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    item_stall = (state != awu_pkg::ST_IDLE);

    mul_req = '0;
    ds_req  = '0;

    w_we = 1'b0;
    m_we = 1'b0;
    v_we = 1'b0;
    w_wd = wsum_clip[31:0];
    m_wd = mn_r;
    v_wd = vn_r;

    unique case (state)
      awu_pkg::ST_DISPATCH: begin
        // load writes the weight and clears both moments
        if (cmd_r == awu_pkg::CMD_LOAD) begin
          w_we = 1'b1;
          m_we = 1'b1;
          v_we = 1'b1;
          w_wd = wval_r;
          m_wd = '0;
          v_wd = '0;
        end
      end
      awu_pkg::ST_GRAD: begin
        // error * activation, both signed
        mul_req.start   = !launched;
        mul_req.clear   = 1'b1;
        mul_req.msb_neg = 1'b1;
        mul_req.mcand   = {{2{err_r[31]}}, err_r};
        mul_req.mult    = act_r;
      end
      awu_pkg::ST_BIAS: begin
        mul_req.start = !launched;
        mul_req.clear = 1'b1;
        mul_req.mcand = {{2{err_r[31]}}, err_r};
        mul_req.mult  = {8'd0, learning_rate};
      end
      awu_pkg::ST_PLAIN: begin
        mul_req.start = !launched;
        mul_req.clear = 1'b1;
        mul_req.mcand = {{2{g_r[31]}}, g_r};
        mul_req.mult  = {8'd0, learning_rate};
      end
      awu_pkg::ST_M1: begin
        mul_req.start = !launched;
        mul_req.clear = 1'b1;
        mul_req.mcand = {{2{m_rd[31]}}, m_rd};
        mul_req.mult  = {8'd0, beta_one};
      end
      awu_pkg::ST_M2: begin
        // accumulates onto beta_one * m
        mul_req.start = !launched;
        mul_req.mcand = {{2{g_r[31]}}, g_r};
        mul_req.mult  = {7'd0, b1_comp};
      end
      awu_pkg::ST_G2: begin
        mul_req.start = !launched;
        mul_req.clear = 1'b1;
        mul_req.mcand = {2'b00, g_abs};
        mul_req.mult  = g_abs;
      end
      awu_pkg::ST_V1: begin
        mul_req.start = !launched;
        mul_req.clear = 1'b1;
        mul_req.mcand = {2'b00, v_rd};
        mul_req.mult  = {8'd0, beta_two};
      end
      awu_pkg::ST_V2: begin
        mul_req.start = !launched;
        mul_req.mcand = {2'b00, g2_r};
        mul_req.mult  = {7'd0, b2_comp};
      end
      awu_pkg::ST_MHAT: begin
        // |m| * 2^24 / (1 - beta_one^t)
        ds_req.start = !launched;
        ds_req.num   = {8'd0, mn_abs, 24'd0};
        ds_req.den   = {12'd0, c1};
      end
      awu_pkg::ST_VHAT: begin
        ds_req.start = !launched;
        ds_req.num   = {8'd0, vn_r, 24'd0};
        ds_req.den   = {12'd0, c2};
      end
      awu_pkg::ST_SQRT: begin
        // radicand vhat * 2^24 sits in the top 56 bits
        ds_req.start   = !launched;
        ds_req.is_sqrt = 1'b1;
        ds_req.num     = {vhat_r, 32'd0};
      end
      awu_pkg::ST_NUM: begin
        mul_req.start = !launched;
        mul_req.clear = 1'b1;
        mul_req.mcand = {2'b00, mhat_abs};
        mul_req.mult  = {8'd0, learning_rate};
      end
      awu_pkg::ST_DELTA: begin
        // product held in the multiplier accumulator, scaled by 2^8
        ds_req.start = !launched;
        ds_req.num   = {acc[55:0], 8'd0};
        ds_req.den   = den_r;
      end
      awu_pkg::ST_WADD: begin
        w_we = 1'b1;
        m_we = adam_wr;
        v_we = adam_wr;
      end
      awu_pkg::ST_ADV1: begin
        mul_req.start = !launched;
        mul_req.clear = 1'b1;
        mul_req.mcand = {9'd0, beta_one_power};
        mul_req.mult  = {8'd0, beta_one};
      end
      awu_pkg::ST_ADV2: begin
        mul_req.start = !launched;
        mul_req.clear = 1'b1;
        mul_req.mcand = {9'd0, beta_two_power};
        mul_req.mult  = {8'd0, beta_two};
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= awu_pkg::ST_IDLE;
      launched       <= 1'b0;
      result_valid   <= 1'b0;
      beta_one_power <= awu_pkg::ONE_Q24;
      beta_two_power <= awu_pkg::ONE_Q24;
      learning_rate  <= awu_pkg::LEARNING_RATE_RST;
      beta_one       <= awu_pkg::BETA_ONE_RST;
      beta_two       <= awu_pkg::BETA_TWO_RST;
      epsilon        <= awu_pkg::EPSILON_RST;
      use_adam       <= 1'b1;
    end else begin
      state <= state_next;

      if (mul_req.start || ds_req.start) begin
        launched <= 1'b1;
      end else if (mul_done || ds_done) begin
        launched <= 1'b0;
      end

      if (state == awu_pkg::ST_FINISH && result_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      if (state == awu_pkg::ST_ADV1 && mul_done) begin
        beta_one_power <= acc[48:24];
      end
      if (state == awu_pkg::ST_ADV2 && mul_done) begin
        beta_two_power <= acc[48:24];
      end

      if (cfg_we) begin
        unique case (cfg_index)
          awu_pkg::REG_LEARNING_RATE: learning_rate <= cfg_data[23:0];
          awu_pkg::REG_BETA_ONE:      beta_one      <= cfg_data[23:0];
          awu_pkg::REG_BETA_TWO:      beta_two      <= cfg_data[23:0];
          awu_pkg::REG_EPSILON:       epsilon       <= cfg_data;
          awu_pkg::REG_USE_ADAM:      use_adam      <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (item_take) begin
      cmd_r   <= cmd;
      idx_r   <= weight_index;
      wval_r  <= weight_value;
      err_r   <= error_term;
      act_r   <= activation;
      bias_r  <= is_bias;
      delta_r <= '0;
      nw_r    <= '0;
      sat_r   <= 1'b0;
      fault_r <= 1'b0;
      adam_wr <= 1'b0;
    end

    case (state)
      awu_pkg::ST_DISPATCH: begin
        if (cmd_r == awu_pkg::CMD_LOAD) begin
          nw_r <= wval_r;
        end else if (cmd_r == awu_pkg::CMD_UPDATE && !bias_r && adam_fault) begin
          // update ahead of any advance: weight untouched
          fault_r <= 1'b1;
          nw_r    <= w_rd;
        end
      end
      awu_pkg::ST_GRAD: begin
        if (mul_done) begin
          g_r   <= acc_clip[31:0];
          sat_r <= sat_r | acc_clip[32];
        end
      end
      awu_pkg::ST_BIAS, awu_pkg::ST_PLAIN: begin
        if (mul_done) begin
          delta_r <= acc_q24[31:0];
        end
      end
      awu_pkg::ST_M2: begin
        if (mul_done) begin
          mn_r <= acc_q24[31:0];
        end
      end
      awu_pkg::ST_G2: begin
        if (mul_done) begin
          if (|acc[awu_pkg::ACC_W-1:56]) begin
            g2_r  <= 32'hffff_ffff;
            sat_r <= 1'b1;
          end else begin
            g2_r <= acc[55:24];
          end
        end
      end
      awu_pkg::ST_V2: begin
        if (mul_done) begin
          vn_r <= acc[55:24];
        end
      end
      awu_pkg::ST_MHAT: begin
        if (ds_done) begin
          mhat_r <= quo_clip[31:0];
          sat_r  <= sat_r | quo_clip[32];
        end
      end
      awu_pkg::ST_VHAT: begin
        if (ds_done) begin
          if (|ds_rsp.quo[awu_pkg::NUM_W-1:32]) begin
            vhat_r <= 32'hffff_ffff;
            sat_r  <= 1'b1;
          end else begin
            vhat_r <= ds_rsp.quo[31:0];
          end
        end
      end
      awu_pkg::ST_SQRT: begin
        if (ds_done) begin
          den_r <= den_calc;
        end
      end
      awu_pkg::ST_DELTA: begin
        if (ds_done) begin
          delta_r <= quo_clip[31:0];
          sat_r   <= sat_r | quo_clip[32];
          adam_wr <= 1'b1;
        end
      end
      awu_pkg::ST_WADD: begin
        nw_r  <= wsum_clip[31:0];
        sat_r <= sat_r | wsum_clip[32];
      end
      awu_pkg::ST_FINISH: begin
        if (result_free) begin
          out_index     <= idx_r;
          new_weight    <= nw_r;
          applied_delta <= delta_r;
          saturated     <= sat_r;
          fault         <= fault_r;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- checks
  `AWU_ASSERT_IMP(a_mul_start_idle, clk, rst, mul_req.start, !mul_rsp.busy, "multiplier restarted while busy")
  `AWU_ASSERT_IMP(a_ds_start_idle, clk, rst, ds_req.start, !ds_rsp.busy, "divider restarted while busy")
  `AWU_ASSERT_IMP(a_one_unit, clk, rst, mul_req.start, !ds_req.start, "both units started together")
  `AWU_ASSERT_IMP(a_fault_clean, clk, rst, result_valid && fault, applied_delta == 32'sd0 && !saturated, "fault result carries a delta or flag")
  `AWU_ASSERT_NEXT(a_accept_read, clk, rst, item_take, state == awu_pkg::ST_READ, "accepted item did not start a read")

endmodule

`default_nettype wire

// ===== bench/adam_weight_update_unit_tb.sv =====
// ----------------------------------------------------------------------------
// adam_weight_update_unit_tb
// self-checking bench for the weight update engine: load, advance, bias,
// plain and adam update items run through a bit-exact fixed point predictor,
// under random sender bursts, receiver stalls and several register settings
// ----------------------------------------------------------------------------
`default_nettype none

module adam_weight_update_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // code 3 is not a command; the block must pass it through untouched
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam longint     Q24_ONE    = 64'd16777216;
  localparam longint unsigned U32_MAX = 64'hFFFF_FFFF;
  localparam int         IDLE_LIMIT = 6000;
  localparam int         HOLD_CYCLES = 700;

  typedef struct {
    logic [1:0]         cmd;
    logic [11:0]        idx;
    logic signed [31:0] wv;
    logic signed [31:0] err;
    logic signed [31:0] act;
    logic               bias;
  } item_t;

  typedef struct {
    logic [11:0]        idx;
    logic signed [31:0] nw;
    logic signed [31:0] delta;
    logic               sat;
    logic               flt;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  cmd = '0;
  logic [11:0] weight_index = '0;
  logic signed [31:0] weight_value = '0;
  logic signed [31:0] error_term = '0;
  logic signed [31:0] activation = '0;
  logic        is_bias = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [11:0] out_index;
  logic signed [31:0] new_weight;
  logic signed [31:0] applied_delta;
  logic        saturated;
  logic        fault;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  adam_weight_update_unit u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .cmd(cmd), .weight_index(weight_index), .weight_value(weight_value),
    .error_term(error_term), .activation(activation), .is_bias(is_bias),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_index(out_index), .new_weight(new_weight), .applied_delta(applied_delta),
    .saturated(saturated), .fault(fault),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: its own copy of the store and the registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] wt_mem [awu_pkg::NUM_WEIGHTS];
  logic signed [31:0] m1_mem [awu_pkg::NUM_WEIGHTS];
  logic [31:0]        m2_mem [awu_pkg::NUM_WEIGHTS];
  logic [24:0]        pow_one, pow_two;
  logic [23:0]        lr_reg, b1_reg, b2_reg;
  logic [31:0]        eps_reg;
  logic               adam_on;

  // slots that hold a loaded weight; only these may be updated
  bit                 slot_live [awu_pkg::NUM_WEIGHTS];
  int                 live_q [$];

  outcome_t           pending_q [$];
  int                 errors = 0;
  int                 n_results = 0, n_sat = 0, n_fault = 0;
  int                 n_load = 0, n_upd = 0, n_adv = 0, n_other = 0;

  // sender pacing and receiver behavior
  int                 burst_left = 0;
  int                 gap_max = 6;
  int                 stall_pct = 0;
  int                 hold_asked = 0;
  int                 hold_served = 0;
  int                 hold_left = 0;

  function automatic longint clip_s32(longint x, inout bit sat);
    if (x > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // magnitude plus sign, clipped to signed 32
  function automatic longint clip_mag(longint unsigned mag, bit neg, inout bit sat);
    if (neg) begin
      if (mag > 64'd2147483648) begin
        sat = 1'b1;
        return -64'sd2147483648;
      end
      return -longint'(mag);
    end
    if (mag > 64'd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(mag);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // bias-corrected step; also advances the slot's moments
  function automatic longint adam_step(int s, longint g, inout bit sat);
    longint          m0, mn, b1, mhat;
    longint unsigned v0, b2, ug, g2, vn, c1, c2, mmag, vhat, den, hmag, num;
    m0 = longint'(m1_mem[s]);
    v0 = longint'(m2_mem[s]);
    b1 = longint'(b1_reg);
    b2 = longint'(b2_reg);
    mn = (b1 * m0 + (Q24_ONE - b1) * g) >>> 24;
    ug = (g < 0) ? -g : g;
    g2 = (ug * ug) >> 24;
    if (g2 > U32_MAX) begin
      g2 = U32_MAX;
      sat = 1'b1;
    end
    vn = (b2 * v0 + (Q24_ONE - b2) * g2) >> 24;
    c1 = Q24_ONE - longint'(pow_one);
    c2 = Q24_ONE - longint'(pow_two);
    mmag = (mn < 0) ? -mn : mn;
    mhat = clip_mag((mmag << 24) / c1, mn < 0, sat);
    vhat = (vn << 24) / c2;
    if (vhat > U32_MAX) begin
      vhat = U32_MAX;
      sat = 1'b1;
    end
    den = (root_floor(vhat << 24) << 8) + longint'(eps_reg);
    if (den == 0) den = 1;
    hmag = (mhat < 0) ? -mhat : mhat;
    num = (longint'(lr_reg) * hmag) << 8;
    m1_mem[s] = mn[31:0];
    m2_mem[s] = vn[31:0];
    return clip_mag(num / den, mhat < 0, sat);
  endfunction

  function automatic outcome_t predict_update(item_t it);
    outcome_t o;
    int       s;
    longint   w, g, d, err, act, lr;
    bit       sat, flt;
    s   = int'(it.idx) % awu_pkg::NUM_WEIGHTS;
    err = longint'(it.err);
    act = longint'(it.act);
    lr  = longint'(lr_reg);
    sat = 1'b0;
    flt = 1'b0;
    d   = 0;
    w   = 0;
    case (it.cmd)
      awu_pkg::CMD_LOAD: begin
        wt_mem[s] = it.wv;
        m1_mem[s] = '0;
        m2_mem[s] = '0;
        w = longint'(it.wv);
      end
      awu_pkg::CMD_ADVANCE: begin
        pow_one = 25'((longint'(pow_one) * longint'(b1_reg)) >> 24);
        pow_two = 25'((longint'(pow_two) * longint'(b2_reg)) >> 24);
      end
      awu_pkg::CMD_UPDATE: begin
        w = longint'(wt_mem[s]);
        if (it.bias) begin
          d = (lr * err) >>> 24;
        end else begin
          g = clip_s32((err * act) >>> 24, sat);
          if (!adam_on) begin
            d = (lr * g) >>> 24;
          end else if (pow_one >= awu_pkg::ONE_Q24 || pow_two >= awu_pkg::ONE_Q24) begin
            // no advance yet: weight and moments stay, only the fault flag
            flt = 1'b1;
            sat = 1'b0;
          end else begin
            d = adam_step(s, g, sat);
          end
        end
        if (!flt) w = clip_s32(w + d, sat);
        wt_mem[s] = w[31:0];
      end
      default: ;
    endcase
    o.idx   = it.idx;
    o.nw    = w[31:0];
    o.delta = d[31:0];
    o.sat   = sat;
    o.flt   = flt;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // item sender: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_item(item_t it);
    int s;
    @(negedge clk);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    item_valid   <= 1'b1;
    cmd          <= it.cmd;
    weight_index <= it.idx;
    weight_value <= it.wv;
    error_term   <= it.err;
    activation   <= it.act;
    is_bias      <= it.bias;
    do @(posedge clk); while (item_stall);
    // accepted at this edge; predict in acceptance order
    pending_q = {pending_q, predict_update(it)};
    s = int'(it.idx) % awu_pkg::NUM_WEIGHTS;
    if (it.cmd == awu_pkg::CMD_LOAD && !slot_live[s]) begin
      slot_live[s] = 1'b1;
      live_q = {live_q, s};
    end
    case (it.cmd)
      awu_pkg::CMD_LOAD:    n_load++;
      awu_pkg::CMD_UPDATE:  n_upd++;
      awu_pkg::CMD_ADVANCE: n_adv++;
      default:              n_other++;
    endcase
  endtask

  // lower valid and wait until every result is back
  task automatic drain;
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write while the block is idle; predictor follows
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      awu_pkg::REG_LEARNING_RATE: lr_reg  = val[23:0];
      awu_pkg::REG_BETA_ONE:      b1_reg  = val[23:0];
      awu_pkg::REG_BETA_TWO:      b2_reg  = val[23:0];
      awu_pkg::REG_EPSILON:       eps_reg = val;
      awu_pkg::REG_USE_ADAM:      adam_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [23:0] lr, logic [23:0] b1, logic [23:0] b2,
                          logic [31:0] eps, logic on);
    write_reg(awu_pkg::REG_LEARNING_RATE, {8'h00, lr});
    write_reg(awu_pkg::REG_BETA_ONE, {8'h00, b1});
    write_reg(awu_pkg::REG_BETA_TWO, {8'h00, b2});
    write_reg(awu_pkg::REG_EPSILON, eps);
    write_reg(awu_pkg::REG_USE_ADAM, {31'd0, on});
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(4))
      0, 1: return $urandom();
      2:    return $signed($urandom_range(33554432)) - 32'sd16777216;
      3:    return $signed($urandom_range(4194304)) - 32'sd2097152;
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic item_t make_item(logic [1:0] c, logic [11:0] idx,
                                      logic signed [31:0] wv, logic signed [31:0] err,
                                      logic signed [31:0] act, logic b);
    item_t it;
    it.cmd = c; it.idx = idx; it.wv = wv; it.err = err; it.act = act; it.bias = b;
    return it;
  endfunction

  // random traffic: mostly updates of loaded slots, some loads, advances and unused commands
  function automatic item_t random_item(int adv_pct);
    item_t it;
    int    r;
    it = make_item(awu_pkg::CMD_LOAD, 12'($urandom()), pick_value(), pick_value(),
                   pick_value(), 1'($urandom_range(1)));
    r = $urandom_range(99);
    if (live_q.size() == 0 || r < 14) begin
      it.cmd = awu_pkg::CMD_LOAD;
      if ($urandom_range(4) != 0)
        it.idx = $urandom_range(1) ? 12'($urandom_range(15)) : 12'(4080 + $urandom_range(15));
    end else if (r < 14 + adv_pct) begin
      it.cmd = awu_pkg::CMD_ADVANCE;
    end else if (r < 17 + adv_pct) begin
      it.cmd = CMD_UNUSED;
    end else begin
      it.cmd  = awu_pkg::CMD_UPDATE;
      it.idx  = 12'(live_q[$urandom_range(live_q.size() - 1)]);
      it.bias = ($urandom_range(9) == 0);
    end
    return it;
  endfunction

  task automatic run_random(int count, int adv_pct);
    repeat (count) send_item(random_item(adv_pct));
  endtask

  // ---------------------------------------------------------------------------
  // result receiver: own stall pattern plus a counted long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      result_stall <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      hold_served  <= hold_asked;
    end else begin
      result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (saturated) n_sat++;
      if (fault) n_fault++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result idx %0d weight %0d", $time, out_index, new_weight);
      end else begin
        exp_o = pending_q.pop_front();
        if (out_index !== exp_o.idx) begin
          errors++;
          $display("%0t: out_index exp %0d got %0d", $time, exp_o.idx, out_index);
        end
        if (new_weight !== exp_o.nw) begin
          errors++;
          $display("%0t: new_weight exp %0d got %0d", $time, exp_o.nw, new_weight);
        end
        if (applied_delta !== exp_o.delta) begin
          errors++;
          $display("%0t: applied_delta exp %0d got %0d", $time, exp_o.delta, applied_delta);
        end
        if (saturated !== exp_o.sat) begin
          errors++;
          $display("%0t: saturated exp %0b got %0b", $time, exp_o.sat, saturated);
        end
        if (fault !== exp_o.flt) begin
          errors++;
          $display("%0t: fault exp %0b got %0b", $time, exp_o.flt, fault);
        end
      end
    end
  end

  // watchdog: cycles with no item accepted on either side
  always @(posedge clk) begin
    int quiet;
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet = 0;
    else
      quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, quiet, pending_q.size());
      $display("adam_weight_update_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, every command, fault before the first advance, saturation,
  // zero gradient, unused command and a plain step
  task automatic test_directed;
    send_item(make_item(awu_pkg::CMD_LOAD, 12'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0));
    send_item(make_item(awu_pkg::CMD_LOAD, 12'd4095, 32'h7FFF_FFFF, 32'sd0, 32'sd0, 1'b0));
    send_item(make_item(awu_pkg::CMD_LOAD, 12'd1, 32'h8000_0000, 32'sd0, 32'sd0, 1'b0));
    send_item(make_item(awu_pkg::CMD_LOAD, 12'd2, 32'h0100_0000, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 1'b1));
    // adam update with beta powers still at one
    send_item(make_item(awu_pkg::CMD_UPDATE, 12'd2, 32'sd0, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 1'b0));
    // bias steps never fault; both push the weight past its range
    send_item(make_item(awu_pkg::CMD_UPDATE, 12'd4095, 32'sd0, 32'h7FFF_FFFF, 32'sd0, 1'b1));
    send_item(make_item(awu_pkg::CMD_UPDATE, 12'd1, 32'sd0, 32'h8000_0000, 32'sd5, 1'b1));
    send_item(make_item(CMD_UNUSED, 12'd2, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    send_item(make_item(awu_pkg::CMD_ADVANCE, 12'd4095, 32'hFFFF_FFFF, 32'sd0, 32'sd0, 1'b0));
    // gradient clips both ways
    send_item(make_item(awu_pkg::CMD_UPDATE, 12'd2, 32'sd0, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 1'b0));
    send_item(make_item(awu_pkg::CMD_UPDATE, 12'd2, 32'sd0, 32'h8000_0000,
                        32'h8000_0000, 1'b0));
    send_item(make_item(awu_pkg::CMD_UPDATE, 12'd2, 32'sd0, 32'h8000_0000,
                        32'h7FFF_FFFF, 1'b0));
    send_item(make_item(awu_pkg::CMD_UPDATE, 12'd0, 32'sd0, 32'sd0, 32'sd0, 1'b0));
    send_item(make_item(awu_pkg::CMD_UPDATE, 12'd0, 32'sd0, 32'sd8388608,
                        -32'sd16777216, 1'b0));
    send_item(make_item(awu_pkg::CMD_UPDATE, 12'd4095, 32'sd0, 32'sd1, 32'sd1, 1'b0));
    write_reg(awu_pkg::REG_USE_ADAM, 32'd0);
    send_item(make_item(awu_pkg::CMD_UPDATE, 12'd1, 32'sd0, 32'h7FFF_FFFF,
                        32'h8000_0000, 1'b0));
    send_item(make_item(awu_pkg::CMD_UPDATE, 12'd0, 32'sd0, 32'sd33554432,
                        -32'sd50331648, 1'b0));
    write_reg(awu_pkg::REG_USE_ADAM, 32'd1);
    send_item(make_item(awu_pkg::CMD_UPDATE, 12'd0, 32'sd0, 32'sd33554432,
                        -32'sd50331648, 1'b0));
  endtask

  // default registers, light pacing, moments accumulate over many steps
  task automatic test_adam_defaults;
    gap_max = 6; stall_pct = 20;
    run_random(420, 6);
    gap_max = 0; stall_pct = 0;
    run_random(80, 6);
  endtask

  // register extremes: zero betas and epsilon give zero denominators
  task automatic test_register_extremes;
    set_regs(24'hFF_FFFF, 24'd0, 24'd0, 32'd0, 1'b1);
    gap_max = 3; stall_pct = 35;
    run_random(120, 8);
    set_regs(24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    run_random(80, 8);
    set_regs(24'd1, 24'd1, 24'hFF_FFFF, 32'd1, 1'b1);
    run_random(60, 8);
  endtask

  // plain gradient steps, moments left alone
  task automatic test_plain_steps;
    set_regs(24'($urandom()), 24'($urandom()), 24'($urandom()), $urandom(), 1'b0);
    gap_max = 10; stall_pct = 50;
    run_random(150, 5);
    write_reg(awu_pkg::REG_LEARNING_RATE, 32'h00FF_FFFF);
    run_random(100, 5);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure;
    set_regs(24'($urandom()), 24'($urandom_range(16000000, 16777215)),
             24'($urandom_range(16000000, 16777215)), $urandom_range(1000), 1'b1);
    gap_max = 0; stall_pct = 0;
    hold_asked++;
    run_random(40, 6);
    stall_pct = 70; gap_max = 2;
    run_random(110, 6);
  endtask

  // random register settings between phases
  task automatic test_random_settings;
    repeat (3) begin
      set_regs(24'($urandom()), 24'($urandom()), 24'($urandom()), $urandom(),
               1'($urandom_range(3) != 0));
      gap_max = $urandom_range(8); stall_pct = $urandom_range(60);
      run_random(95, 7);
    end
  endtask

  initial begin
    for (int i = 0; i < awu_pkg::NUM_WEIGHTS; i++) slot_live[i] = 1'b0;
    pow_one = awu_pkg::ONE_Q24;
    pow_two = awu_pkg::ONE_Q24;
    lr_reg  = awu_pkg::LEARNING_RATE_RST;
    b1_reg  = awu_pkg::BETA_ONE_RST;
    b2_reg  = awu_pkg::BETA_TWO_RST;
    eps_reg = awu_pkg::EPSILON_RST;
    adam_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_adam_defaults();
    test_register_extremes();
    test_plain_steps();
    test_backpressure();
    test_random_settings();
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d loads, %0d updates, %0d advances, %0d unused commands",
             n_load, n_upd, n_adv, n_other);
    $display("checked %0d results, %0d saturating, %0d faulting, over default, extreme and random registers",
             n_results, n_sat, n_fault);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("adam_weight_update_unit: match");
    end else begin
      $display("adam_weight_update_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
